// File: hdl/length_prefixed_message_ring_core_defines.svh
// Shared assertion macros for the message ring.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define LPMR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpmr assertion failed");

// Check that cons holds in the cycle after ante.
`define LPMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpmr assertion failed");

`endif

// File: hdl/lpmr_pkg.sv
`timescale 1ns / 1ps
package lpmr_pkg;

    localparam int BUF_DEPTH_DEFAULT  = 1024;
    localparam int RING_LENGTH_RESET  = 1024;
    localparam int MIN_RING_LENGTH    = 4;
    localparam int CFG_WIDTH          = 11;
    localparam int SIZE_OVERHEAD      = 3;
    localparam int FREE_RESERVE       = 1;

    localparam logic [1:0] MODE_BEGIN_PUT = 2'd0;
    localparam logic [1:0] MODE_PUT_BYTE  = 2'd1;
    localparam logic [1:0] MODE_BEGIN_GET = 2'd2;
    localparam logic [1:0] MODE_GET_BYTE  = 2'd3;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NO_MSG    = 3'd1;
    localparam logic [2:0] STATUS_TOO_SMALL = 3'd2;
    localparam logic [2:0] STATUS_TOO_LARGE = 3'd3;
    localparam logic [2:0] STATUS_NO_SPACE  = 3'd4;
    localparam logic [2:0] STATUS_SEQ       = 3'd5;

    typedef enum logic
    {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

// File: hdl/lpmr_ram.sv
`timescale 1ns / 1ps
module lpmr_ram
    import lpmr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = BUF_DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/length_prefixed_message_ring_core.sv
`timescale 1ns / 1ps
// Length-prefixed message ring.
// Input channel s_axis: tuser carries the mode (begin_put, put_byte, begin_get,
// get_byte), tdata the length and the body byte. Output channel m_axis: one
// item for every input item, tuser the status, tdata the read byte and the
// message length, tlast the last flag of a put or get message.
// cfg_we/cfg_wdata set the ring length (clamped to 4..BUF_DEPTH) and empty the
// ring; write it only while no item is in flight.
// Put items give their result in the output register in the cycle after
// acceptance; get items first read the ring memory, whose read data is
// registered, and then give their result in the output register from the
// ST_READ state. One item is in work at a time.
// The output register holds a result while m_axis_tready is low; the next
// item is taken in the same cycle the waiting result leaves.
// Reset empties the ring, drops any put or get in progress and sets the ring
// length to 1024 (or BUF_DEPTH if smaller). Memory contents are not cleared.
module length_prefixed_message_ring_core
    import lpmr_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // length[7:0], data_byte[15:8]
    input  logic [1:0]           s_axis_tuser,   // mode[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // read_byte[7:0], message_length[15:8]
    output logic [2:0]           m_axis_tuser,   // status[2:0]
    output logic                 m_axis_tlast
);

`include "length_prefixed_message_ring_core_defines.svh"

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int LW = $clog2(BUF_DEPTH + 1);
    localparam int CW = (LW > CFG_WIDTH) ? LW : CFG_WIDTH;
    localparam int SW = ((LW > 9) ? LW : 9) + 1;
    localparam int RESET_LEN = (BUF_DEPTH < RING_LENGTH_RESET) ? BUF_DEPTH : RING_LENGTH_RESET;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p, input logic [LW-1:0] len);
        logic [LW-1:0] n;
        n = LW'(p) + LW'(1);
        return (n >= len) ? AW'(0) : n[AW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [LW-1:0] ring_len_reg, ring_len_next;
    logic [AW-1:0] read_ptr_reg, read_ptr_next;
    logic [AW-1:0] write_ptr_reg, write_ptr_next;
    logic [AW-1:0] put_cursor_reg, put_cursor_next;
    logic [7:0]    put_rem_reg, put_rem_next;
    logic          put_active_reg, put_active_next;
    logic [AW-1:0] get_cursor_reg, get_cursor_next;
    logic [7:0]    get_rem_reg, get_rem_next;
    logic          get_active_reg, get_active_next;
    logic [1:0]    op_mode_reg, op_mode_next;
    logic [7:0]    op_len_reg, op_len_next;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [7:0]    out_rbyte_reg, out_rbyte_next;
    logic [7:0]    out_mlen_reg, out_mlen_next;
    logic          out_last_reg, out_last_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_free;
    logic          accept;
    logic [1:0]    in_mode;
    logic [7:0]    in_len;
    logic [7:0]    in_data;
    logic [AW-1:0] adv_wp, adv_pc, adv_rp, adv_gc;
    logic [SW-1:0] used;
    logic          too_large;
    logic          no_space;
    logic [CW-1:0] cfg_ext;
    logic [LW-1:0] cfg_len;

    lpmr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_mode  = s_axis_tuser;
    assign in_len   = s_axis_tdata[7:0];
    assign in_data  = s_axis_tdata[15:8];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;

    assign adv_wp = advance(write_ptr_reg, ring_len_reg);
    assign adv_pc = advance(put_cursor_reg, ring_len_reg);
    assign adv_rp = advance(read_ptr_reg, ring_len_reg);
    assign adv_gc = advance(get_cursor_reg, ring_len_reg);

    assign used = (write_ptr_reg >= read_ptr_reg)
                ? SW'(write_ptr_reg) - SW'(read_ptr_reg)
                : SW'(write_ptr_reg) + SW'(ring_len_reg) - SW'(read_ptr_reg);
    assign too_large = (SW'(in_len) + SW'(SIZE_OVERHEAD)) > SW'(ring_len_reg);
    assign no_space  = (SW'(in_len) + used + SW'(2 * FREE_RESERVE)) > SW'(ring_len_reg);

    assign cfg_ext = CW'(cfg_wdata);
    assign cfg_len = (cfg_ext < CW'(MIN_RING_LENGTH)) ? LW'(MIN_RING_LENGTH)
                   : (cfg_ext > CW'(BUF_DEPTH))       ? LW'(BUF_DEPTH)
                   : LW'(cfg_ext);

    always_comb
    begin
        state_next      = state_reg;
        ring_len_next   = ring_len_reg;
        read_ptr_next   = read_ptr_reg;
        write_ptr_next  = write_ptr_reg;
        put_cursor_next = put_cursor_reg;
        put_rem_next    = put_rem_reg;
        put_active_next = put_active_reg;
        get_cursor_next = get_cursor_reg;
        get_rem_next    = get_rem_reg;
        get_active_next = get_active_reg;
        op_mode_next    = op_mode_reg;
        op_len_next     = op_len_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_rbyte_next  = out_rbyte_reg;
        out_mlen_next   = out_mlen_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = write_ptr_reg;
        ram_wdata       = in_len;
        ram_re          = 1'b0;
        ram_raddr       = read_ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        MODE_BEGIN_PUT:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_OK;
                            out_rbyte_next  = 8'd0;
                            out_mlen_next   = 8'd0;
                            out_last_next   = 1'b0;
                            put_active_next = 1'b0;
                            if (too_large)
                            begin
                                out_status_next = STATUS_TOO_LARGE;
                            end
                            else if (no_space)
                            begin
                                out_status_next = STATUS_NO_SPACE;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = write_ptr_reg;
                                ram_wdata       = in_len;
                                put_cursor_next = adv_wp;
                                put_rem_next    = in_len;
                                if (in_len == 8'd0)
                                begin
                                    write_ptr_next = adv_wp;
                                    out_last_next  = 1'b1;
                                end
                                else
                                begin
                                    put_active_next = 1'b1;
                                end
                            end
                        end
                        MODE_PUT_BYTE:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_OK;
                            out_rbyte_next  = 8'd0;
                            out_mlen_next   = 8'd0;
                            out_last_next   = 1'b0;
                            if (!put_active_reg)
                            begin
                                out_status_next = STATUS_SEQ;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = put_cursor_reg;
                                ram_wdata       = in_data;
                                put_cursor_next = adv_pc;
                                put_rem_next    = put_rem_reg - 8'd1;
                                if (put_rem_reg == 8'd1)
                                begin
                                    write_ptr_next  = adv_pc;
                                    put_active_next = 1'b0;
                                    out_last_next   = 1'b1;
                                end
                            end
                        end
                        MODE_BEGIN_GET:
                        begin
                            ram_re       = 1'b1;
                            ram_raddr    = read_ptr_reg;
                            op_mode_next = in_mode;
                            op_len_next  = in_len;
                            state_next   = ST_READ;
                        end
                        MODE_GET_BYTE:
                        begin
                            ram_re       = 1'b1;
                            ram_raddr    = get_cursor_reg;
                            op_mode_next = in_mode;
                            op_len_next  = in_len;
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_rbyte_next  = 8'd0;
                    out_mlen_next   = 8'd0;
                    out_last_next   = 1'b0;
                    case (op_mode_reg)
                        MODE_BEGIN_GET:
                        begin
                            get_active_next = 1'b0;
                            if (read_ptr_reg == write_ptr_reg)
                            begin
                                out_status_next = STATUS_NO_MSG;
                            end
                            else
                            begin
                                out_mlen_next = ram_rdata;
                                if (op_len_reg < ram_rdata)
                                begin
                                    out_status_next = STATUS_TOO_SMALL;
                                end
                                else
                                begin
                                    get_cursor_next = adv_rp;
                                    get_rem_next    = ram_rdata;
                                    if (ram_rdata == 8'd0)
                                    begin
                                        read_ptr_next = adv_rp;
                                        out_last_next = 1'b1;
                                    end
                                    else
                                    begin
                                        get_active_next = 1'b1;
                                    end
                                end
                            end
                        end
                        MODE_GET_BYTE:
                        begin
                            if (!get_active_reg)
                            begin
                                out_status_next = STATUS_SEQ;
                            end
                            else
                            begin
                                out_rbyte_next  = ram_rdata;
                                get_cursor_next = adv_gc;
                                get_rem_next    = get_rem_reg - 8'd1;
                                if (get_rem_reg == 8'd1)
                                begin
                                    read_ptr_next   = adv_gc;
                                    get_active_next = 1'b0;
                                    out_last_next   = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            out_status_next = STATUS_SEQ;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            ring_len_next   = cfg_len;
            read_ptr_next   = '0;
            write_ptr_next  = '0;
            put_cursor_next = '0;
            put_rem_next    = 8'd0;
            put_active_next = 1'b0;
            get_cursor_next = '0;
            get_rem_next    = 8'd0;
            get_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_len_reg   <= LW'(RESET_LEN);
            read_ptr_reg   <= '0;
            write_ptr_reg  <= '0;
            put_cursor_reg <= '0;
            put_rem_reg    <= 8'd0;
            put_active_reg <= 1'b0;
            get_cursor_reg <= '0;
            get_rem_reg    <= 8'd0;
            get_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ring_len_reg   <= ring_len_next;
            read_ptr_reg   <= read_ptr_next;
            write_ptr_reg  <= write_ptr_next;
            put_cursor_reg <= put_cursor_next;
            put_rem_reg    <= put_rem_next;
            put_active_reg <= put_active_next;
            get_cursor_reg <= get_cursor_next;
            get_rem_reg    <= get_rem_next;
            get_active_reg <= get_active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg    <= op_mode_next;
        op_len_reg     <= op_len_next;
        out_status_reg <= out_status_next;
        out_rbyte_reg  <= out_rbyte_next;
        out_mlen_reg   <= out_mlen_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_mlen_reg, out_rbyte_reg};
    assign m_axis_tlast  = out_last_reg;

    `LPMR_ASSERT_SAME(a_ptrs_in_ring, clk, rst_n, 1'b1,
        (LW'(write_ptr_reg) < ring_len_reg) && (LW'(read_ptr_reg) < ring_len_reg))
    `LPMR_ASSERT_SAME(a_put_rem_nonzero, clk, rst_n, put_active_reg, put_rem_reg != 8'd0)
    `LPMR_ASSERT_SAME(a_get_rem_nonzero, clk, rst_n, get_active_reg, get_rem_reg != 8'd0)
    `LPMR_ASSERT_NEXT(a_put_result_next, clk, rst_n, accept && !in_mode[1],
        m_axis_tvalid && (state_reg == ST_IDLE))
    `LPMR_ASSERT_NEXT(a_get_reads_ram, clk, rst_n, accept && in_mode[1],
        (state_reg == ST_READ) && !s_axis_tready)

endmodule
